// ===== rtl/plcm_pkg.sv =====
// ----------------------------------------------------------------------------
// plcm_pkg
// Shared types and constants of the piecewise linear colour map.
// ----------------------------------------------------------------------------
package plcm_pkg;

    localparam int VAL_W         = 17;
    localparam int BP_W          = 17;
    localparam int RGB_W         = 24;
    localparam int CH_W          = 8;
    localparam int KNOT_W        = 41;
    localparam int KNOT_BP_LSB   = 24;
    localparam int CNT_W         = 3;
    localparam int IDX_W         = 4;
    localparam int NUM_KNOT_REGS = 7;
    localparam int Q_DEPTH       = 2;
    localparam int Q_AW          = 1;

    localparam logic [IDX_W-1:0] REG_KNOT_COUNT = 4'd0;
    localparam logic [IDX_W-1:0] REG_KNOT_0     = 4'd1;

    localparam logic [CNT_W-1:0]  KNOT_COUNT_RST = 3'd2;
    localparam logic [KNOT_W-1:0] KNOT_1_RST     = 41'h100_00FF_FFFF;

    typedef enum logic [1:0] {
        FM_ZERO,
        FM_ONE,
        FM_DIV,
        FM_OOR
    } t_fmode;

    typedef struct packed {
        t_fmode             mode;
        logic [VAL_W-1:0]   num;
        logic [BP_W-1:0]    den;
        logic [RGB_W-1:0]   col_lo;
        logic [RGB_W-1:0]   col_hi;
        logic               row_end;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

// ===== rtl/piecewise_linear_color_map.sv =====
// ----------------------------------------------------------------------------
// piecewise_linear_color_map
// Maps a normalised intensity to an RGB colour by interpolating between knots.
// ----------------------------------------------------------------------------
// The front end registers a sample, picks its segment and queues a job; the
// back end handles one job at a time. A value beyond 1.0 goes straight to the
// sum step, one on or outside its segment's breakpoints through the multiply
// step, and one strictly inside a segment first through the restoring divider,
// which yields one quotient bit a cycle. The front end takes samples while the
// two-entry queue has room; a finished word waits in the output register and
// holds the next result in the sum step. Knot registers must be written by the
// user through the configuration port only while idle; the block does not enforce this.
// ----------------------------------------------------------------------------
module piecewise_linear_color_map #(
    parameter int MAX_KNOTS = 7,
    parameter int FRAC_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [plcm_pkg::VAL_W-1:0]    i_value_frac,
    input  logic                          i_row_end,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [plcm_pkg::CH_W-1:0]     o_red,
    output logic [plcm_pkg::CH_W-1:0]     o_green,
    output logic [plcm_pkg::CH_W-1:0]     o_blue,
    output logic                          o_out_of_range,
    output logic                          o_row_end_out,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [plcm_pkg::IDX_W-1:0]    i_cfg_index,
    input  logic [plcm_pkg::KNOT_W-1:0]   i_cfg_data
);
    import plcm_pkg::*;

    localparam int NK = (MAX_KNOTS < NUM_KNOT_REGS) ? MAX_KNOTS : NUM_KNOT_REGS;

    logic [CNT_W-1:0]   r_knot_count;
    logic [KNOT_W-1:0]  r_knot [NK];

    logic               push;
    logic               pop;
    t_job               front_job;
    t_job               q_job;
    t_q_stat            q_stat;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_knot_count <= KNOT_COUNT_RST;
            for (int i = 0; i < NK; i++) begin
                r_knot[i] <= (i == 1) ? KNOT_1_RST : '0;
            end
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == REG_KNOT_COUNT) begin
                r_knot_count <= i_cfg_data[CNT_W-1:0];
            end
            for (int i = 0; i < NK; i++) begin
                if (i_cfg_index == REG_KNOT_0 + IDX_W'(i)) begin
                    r_knot[i] <= i_cfg_data;
                end
            end
        end
    end

    plcm_front #(
        .NK (NK),
        .FB (FRAC_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_value_frac (i_value_frac),
        .i_row_end    (i_row_end),
        .i_knot_count (r_knot_count),
        .i_knot       (r_knot),
        .i_q          (q_stat),
        .o_push       (push),
        .o_job        (front_job)
    );

    plcm_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .i_pop   (pop),
        .o_job   (q_job),
        .o_stat  (q_stat)
    );

    plcm_back #(
        .FB (FRAC_BITS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_job          (q_job),
        .i_q            (q_stat),
        .o_pop          (pop),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_red          (o_red),
        .o_green        (o_green),
        .o_blue         (o_blue),
        .o_out_of_range (o_out_of_range),
        .o_row_end_out  (o_row_end_out)
    );

endmodule

// ===== rtl/plcm_front.sv =====
// ----------------------------------------------------------------------------
// plcm_front
// Takes a sample, finds its segment and sorts it into a job for the back end.
// ----------------------------------------------------------------------------
module plcm_front #(
    parameter int NK = 7,
    parameter int FB = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [plcm_pkg::VAL_W-1:0]    i_value_frac,
    input  logic                          i_row_end,
    input  logic [plcm_pkg::CNT_W-1:0]    i_knot_count,
    input  logic [plcm_pkg::KNOT_W-1:0]   i_knot [NK],
    input  plcm_pkg::t_q_stat             i_q,
    output logic                          o_push,
    output plcm_pkg::t_job                o_job
);
    import plcm_pkg::*;

    localparam int KW = (NK > 2) ? $clog2(NK) : 1;
    localparam int OW = VAL_W + FB;
    localparam logic [OW-1:0] ONE_W = OW'(1) << FB;

    logic               r_in_valid;
    logic [VAL_W-1:0]   r_in_v;
    logic               r_in_rend;

    logic [BP_W-1:0]    bp [NK];
    logic [CNT_W-1:0]   n_used;
    logic [KW-1:0]      k;
    logic [KW-1:0]      kp1;
    logic [BP_W-1:0]    lo;
    logic [BP_W-1:0]    hi;

    assign o_stall = r_in_valid && i_q.full;
    assign o_push  = r_in_valid && !i_q.full;

    always_comb begin
        for (int i = 0; i < NK; i++) begin
            bp[i] = i_knot[i][KNOT_BP_LSB +: BP_W];
        end
        if (i_knot_count < CNT_W'(2)) begin
            n_used = CNT_W'(2);
        end else if (i_knot_count > CNT_W'(NK)) begin
            n_used = CNT_W'(NK);
        end else begin
            n_used = i_knot_count;
        end
        k = KW'(n_used - CNT_W'(2));
        for (int j = NK - 3; j >= 0; j--) begin
            if ((j + 2) < int'(n_used) && r_in_v <= bp[j+1]) begin
                k = KW'(j);
            end
        end
        kp1 = k + KW'(1);
        lo  = bp[k];
        hi  = bp[kp1];

        o_job.num     = r_in_v - lo;
        o_job.den     = hi - lo;
        o_job.col_lo  = i_knot[k][RGB_W-1:0];
        o_job.col_hi  = i_knot[kp1][RGB_W-1:0];
        o_job.row_end = r_in_rend;
        if (OW'(r_in_v) > ONE_W) begin
            o_job.mode = FM_OOR;
        end else if (r_in_v <= lo) begin
            o_job.mode = FM_ZERO;
        end else if (r_in_v >= hi) begin
            o_job.mode = FM_ONE;
        end else begin
            o_job.mode = FM_DIV;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            if (o_push) begin
                r_in_valid <= 1'b0;
            end
            if (i_valid && !o_stall) begin
                r_in_valid <= 1'b1;
                r_in_v     <= i_value_frac;
                r_in_rend  <= i_row_end;
            end
        end
    end

endmodule

// ===== rtl/plcm_fifo.sv =====
// ----------------------------------------------------------------------------
// plcm_fifo
// Short job queue between the front and back ends.
// ----------------------------------------------------------------------------
module plcm_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  plcm_pkg::t_job    i_job,
    input  logic              i_pop,
    output plcm_pkg::t_job    o_job,
    output plcm_pkg::t_q_stat o_stat
);
    import plcm_pkg::*;

    t_job              r_mem [Q_DEPTH];
    logic [Q_AW-1:0]   r_wp;
    logic [Q_AW-1:0]   r_rp;
    logic [Q_AW:0]     r_cnt;
    logic              do_push;
    logic              do_pop;

    assign o_stat.full  = (r_cnt == (Q_AW+1)'(Q_DEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_job        = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_mem[r_wp] <= i_job;
                r_wp        <= r_wp + Q_AW'(1);
            end
            if (do_pop) begin
                r_rp <= r_rp + Q_AW'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + (Q_AW+1)'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - (Q_AW+1)'(1);
            end
        end
    end

endmodule

// ===== rtl/plcm_back.sv =====
// ----------------------------------------------------------------------------
// plcm_back
// Works out the blend fraction (bit-serial division inside a segment), blends
// the two knot colours, black beyond 1.0, and holds the result in the output register.
// ----------------------------------------------------------------------------
module plcm_back #(
    parameter int FB = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  plcm_pkg::t_job              i_job,
    input  plcm_pkg::t_q_stat           i_q,
    output logic                        o_pop,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [plcm_pkg::CH_W-1:0]   o_red,
    output logic [plcm_pkg::CH_W-1:0]   o_green,
    output logic [plcm_pkg::CH_W-1:0]   o_blue,
    output logic                        o_out_of_range,
    output logic                        o_row_end_out
);
    import plcm_pkg::*;

    localparam int FW   = FB + 1;
    localparam int CNTW = $clog2(FB);
    localparam int PW   = FB + 11;
    localparam logic [FW-1:0] ONE_F = FW'(1) << FB;
    localparam logic [PW-1:0] HALF  = PW'(1) << (FB - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_MUL,
        S_SUM
    } t_state;

    t_state                 r_state;
    t_job                   r_job;
    logic [VAL_W-1:0]       r_rem;
    logic [FB-1:0]          r_quo;
    logic [CNTW-1:0]        r_cnt;
    logic [FW-1:0]          r_f;
    logic signed [PW-1:0]   r_prod [3];
    logic                   r_out_valid;

    logic [VAL_W:0]         rem2;
    logic                   ge;
    logic [VAL_W-1:0]       n_rem;
    logic [FB-1:0]          n_quo;
    logic signed [PW-1:0]   n_prod [3];
    logic [CH_W-1:0]        res [3];
    logic signed [CH_W:0]   diff;
    logic signed [PW-1:0]   sum;

    assign o_pop   = (r_state == S_IDLE) && !i_q.empty;
    assign o_valid = r_out_valid;

    always_comb begin
        rem2  = {r_rem, 1'b0};
        ge    = rem2 >= {1'b0, r_job.den};
        n_rem = ge ? VAL_W'(rem2 - {1'b0, r_job.den}) : VAL_W'(rem2);
        n_quo = {r_quo[FB-2:0], ge};
        diff  = '0;
        sum   = '0;
        for (int c = 0; c < 3; c++) begin
            diff = $signed({1'b0, r_job.col_hi[c*CH_W +: CH_W]})
                 - $signed({1'b0, r_job.col_lo[c*CH_W +: CH_W]});
            n_prod[c] = PW'(diff) * $signed(PW'({1'b0, r_f}));
            sum = $signed(PW'({r_job.col_lo[c*CH_W +: CH_W], {FB{1'b0}}}))
                + r_prod[c] + $signed(HALF);
            res[c] = sum[FB +: CH_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (!i_q.empty) begin
                        r_job <= i_job;
                        case (i_job.mode)
                            FM_OOR: begin
                                r_state <= S_SUM;
                            end
                            FM_ZERO: begin
                                r_f     <= '0;
                                r_state <= S_MUL;
                            end
                            FM_ONE: begin
                                r_f     <= ONE_F;
                                r_state <= S_MUL;
                            end
                            FM_DIV: begin
                                r_rem   <= i_job.num;
                                r_quo   <= '0;
                                r_cnt   <= CNTW'(FB - 1);
                                r_state <= S_DIV;
                            end
                            default: begin
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_DIV: begin
                    r_rem <= n_rem;
                    r_quo <= n_quo;
                    r_cnt <= r_cnt - CNTW'(1);
                    if (r_cnt == '0) begin
                        r_f     <= {1'b0, n_quo};
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    for (int c = 0; c < 3; c++) begin
                        r_prod[c] <= n_prod[c];
                    end
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    if (!r_out_valid || !i_stall) begin
                        r_out_valid    <= 1'b1;
                        o_row_end_out  <= r_job.row_end;
                        if (r_job.mode == FM_OOR) begin
                            o_red          <= '0;
                            o_green        <= '0;
                            o_blue         <= '0;
                            o_out_of_range <= 1'b1;
                        end else begin
                            o_red          <= res[2];
                            o_green        <= res[1];
                            o_blue         <= res[0];
                            o_out_of_range <= 1'b0;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== rtl/plcm_checker.sv =====
// ----------------------------------------------------------------------------
// plcm_checker
// Port-level checks on the colour map, bound to the top level.
// ----------------------------------------------------------------------------
module plcm_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        o_stall,
    input  logic        o_valid,
    input  logic        i_stall,
    input  logic [7:0]  o_red,
    input  logic [7:0]  o_green,
    input  logic [7:0]  o_blue,
    input  logic        o_out_of_range,
    input  logic        o_row_end_out
);

    a_rst_out_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result word valid straight after reset");

    a_rst_in_open: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_stall)
        else $error("input stalled straight after reset");

    a_oor_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_out_of_range |-> o_red == 8'd0 && o_green == 8'd0 && o_blue == 8'd0)
        else $error("out of range word not black");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_red) && $stable(o_green)
            && $stable(o_blue) && $stable(o_out_of_range) && $stable(o_row_end_out))
        else $error("stalled result word changed");

endmodule

bind piecewise_linear_color_map plcm_checker u_plcm_checker (.*);

// ===== test/plcm_colour_checker.sv =====
// ----------------------------------------------------------------------------
// plcm_colour_checker
// Watches the sample, colour and configuration channels of the colour map,
// keeps its own copy of the knot registers, predicts the colour word for
// every accepted sample and compares each accepted colour word field by
// field against the oldest prediction.
// ----------------------------------------------------------------------------
module plcm_colour_checker
    import plcm_pkg::*;
#(
    parameter int MAX_KNOTS = 7,
    parameter int FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               o_stall,
    input  logic [VAL_W-1:0]   i_value_frac,
    input  logic               i_row_end,
    input  logic               o_valid,
    input  logic               i_stall,
    input  logic [CH_W-1:0]    o_red,
    input  logic [CH_W-1:0]    o_green,
    input  logic [CH_W-1:0]    o_blue,
    input  logic               o_out_of_range,
    input  logic               o_row_end_out,
    input  logic               i_cfg_valid,
    input  logic               o_cfg_ready,
    input  logic [IDX_W-1:0]   i_cfg_index,
    input  logic [KNOT_W-1:0]  i_cfg_data,
    output int                 o_fail_count,
    output int                 o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
        logic            out_of_range;
        logic            row_end;
    } t_colour;

    t_colour           expected_colours[$];
    logic [CNT_W-1:0]  map_count;
    logic [KNOT_W-1:0] map_knots [NUM_KNOT_REGS];
    int                errors = 0;
    int                pending_cnt = 0;

    assign o_fail_count = errors;
    assign o_pending    = pending_cnt;

    function automatic longint unsigned breakpoint(input int unsigned idx);
        return map_knots[idx][KNOT_W-1:KNOT_BP_LSB];
    endfunction

    function automatic logic [CH_W-1:0] blend(input longint unsigned w_lo,
                                              input longint unsigned w_hi,
                                              input logic [CH_W-1:0] c_lo,
                                              input logic [CH_W-1:0] c_hi);
        return CH_W'((w_lo * c_lo + w_hi * c_hi + ((64'd1 << FRAC_BITS) >> 1)) >> FRAC_BITS);
    endfunction

    function automatic t_colour predict_colour(input logic [VAL_W-1:0] v, input logic re);
        t_colour           c;
        int unsigned       used;
        int unsigned       seg;
        longint unsigned   one;
        longint unsigned   lo;
        longint unsigned   hi;
        longint unsigned   f;
        logic [RGB_W-1:0]  col_lo;
        logic [RGB_W-1:0]  col_hi;
        c = '0;
        c.row_end = re;
        one = 64'd1 << FRAC_BITS;
        if (v > one) begin
            c.out_of_range = 1'b1;
            return c;
        end
        used = map_count;
        if (used < 2) used = 2;
        if (used > MAX_KNOTS) used = MAX_KNOTS;
        if (used > NUM_KNOT_REGS) used = NUM_KNOT_REGS;
        seg = 0;
        while (seg + 2 < used && v > breakpoint(seg + 1)) seg++;
        lo = breakpoint(seg);
        hi = breakpoint(seg + 1);
        if (v <= lo) f = 0;
        else if (v >= hi) f = one;
        else f = ((v - lo) << FRAC_BITS) / (hi - lo);
        col_lo = map_knots[seg][RGB_W-1:0];
        col_hi = map_knots[seg + 1][RGB_W-1:0];
        c.red   = blend(one - f, f, col_lo[23:16], col_hi[23:16]);
        c.green = blend(one - f, f, col_lo[15:8],  col_hi[15:8]);
        c.blue  = blend(one - f, f, col_lo[7:0],   col_hi[7:0]);
        return c;
    endfunction

    task automatic compare_field(input string name, input logic [CH_W-1:0] want,
                                 input logic [CH_W-1:0] got);
        if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_colour want;
        if (!i_rst_n) begin
            map_count = KNOT_COUNT_RST;
            foreach (map_knots[k]) map_knots[k] = '0;
            map_knots[1] = KNOT_1_RST;
            expected_colours.delete();
            pending_cnt <= 0;
        end else begin
            if (i_valid && !o_stall)
                expected_colours.push_back(predict_colour(i_value_frac, i_row_end));
            if (o_valid && !i_stall) begin
                if (expected_colours.size() == 0) begin
                    errors++;
                    $display("%0t: colour word with none expected, %s r=%0d g=%0d b=%0d",
                             $time, "got", o_red, o_green, o_blue);
                    $display("%0t: unexpected word oor=%0b re=%0b",
                             $time, o_out_of_range, o_row_end_out);
                end else begin
                    want = expected_colours.pop_front();
                    compare_field("red", want.red, o_red);
                    compare_field("green", want.green, o_green);
                    compare_field("blue", want.blue, o_blue);
                    compare_field("out_of_range", want.out_of_range, o_out_of_range);
                    compare_field("row_end_out", want.row_end, o_row_end_out);
                end
            end
            // register write lands after the sample taken on the same edge
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == REG_KNOT_COUNT)
                    map_count = i_cfg_data[CNT_W-1:0];
                else if (i_cfg_index >= REG_KNOT_0 && i_cfg_index < REG_KNOT_0 + NUM_KNOT_REGS)
                    map_knots[i_cfg_index - REG_KNOT_0] = i_cfg_data;
            end
            pending_cnt <= expected_colours.size();
        end
    end

endmodule

// ===== test/piecewise_linear_color_map_tb.sv =====
// ----------------------------------------------------------------------------
// piecewise_linear_color_map_tb
// Drives intensity samples and knot maps into the colour map: a directed
// pass over the reset map, breakpoint edges, out-of-range values, clamped
// knot counts and disordered knots, then random maps with samples clustered
// round the breakpoints. Sender bursts and receiver stalls are random; the
// checker beside the block does the prediction and comparison.
// ----------------------------------------------------------------------------
module piecewise_linear_color_map_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import plcm_pkg::*;

    localparam int MAX_KNOTS       = 7;
    localparam int FRAC_BITS       = 16;
    localparam int VAL_MAX         = (1 << VAL_W) - 1;
    localparam int ITEMS_PER_PHASE = 125;
    localparam int RANDOM_PHASES   = 10;
    localparam int HOLD_PHASE      = 2;
    localparam int GAPLESS_PHASE   = 5;
    localparam int LONG_HOLD       = 300;
    localparam int SETTLE          = 30;
    localparam int END_WAIT        = 60;
    localparam int WATCHDOG_LIMIT  = 5000;

    localparam logic [IDX_W-1:0] REG_SPARE_FIRST = REG_KNOT_0 + IDX_W'(NUM_KNOT_REGS);
    localparam logic [IDX_W-1:0] REG_SPARE_LAST  = '1;

    typedef enum int {STALL_NONE, STALL_HALF, STALL_HEAVY, STALL_TOGGLE} t_stall_mode;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic [VAL_W-1:0]   i_value_frac;
    logic               i_row_end;
    logic               o_valid;
    logic               i_stall;
    logic [CH_W-1:0]    o_red;
    logic [CH_W-1:0]    o_green;
    logic [CH_W-1:0]    o_blue;
    logic               o_out_of_range;
    logic               o_row_end_out;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [IDX_W-1:0]   i_cfg_index;
    logic [KNOT_W-1:0]  i_cfg_data;

    int                 fail_count;
    int                 pending;
    int                 idle_cycles = 0;
    int                 burst_left;
    bit                 gapless;
    bit                 hold_req;
    logic [CNT_W-1:0]   map_count;
    logic [KNOT_W-1:0]  map_knots [NUM_KNOT_REGS];

    piecewise_linear_color_map #(
        .MAX_KNOTS (MAX_KNOTS),
        .FRAC_BITS (FRAC_BITS)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_value_frac   (i_value_frac),
        .i_row_end      (i_row_end),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_red          (o_red),
        .o_green        (o_green),
        .o_blue         (o_blue),
        .o_out_of_range (o_out_of_range),
        .o_row_end_out  (o_row_end_out),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    plcm_colour_checker #(
        .MAX_KNOTS (MAX_KNOTS),
        .FRAC_BITS (FRAC_BITS)
    ) checker_i (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_value_frac   (i_value_frac),
        .i_row_end      (i_row_end),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_red          (o_red),
        .o_green        (o_green),
        .o_blue         (o_blue),
        .o_out_of_range (o_out_of_range),
        .o_row_end_out  (o_row_end_out),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("piecewise_linear_color_map_tb: FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : receiver
        t_stall_mode mode;
        int          span;
        bit          hold_done;
        hold_done = 1'b0;
        i_stall <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                i_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else begin
                mode = t_stall_mode'($urandom_range(0, 3));
                span = $urandom_range(1, 60);
                repeat (span) begin
                    case (mode)
                        STALL_NONE:  i_stall <= 1'b0;
                        STALL_HALF:  i_stall <= 1'($urandom_range(0, 1));
                        STALL_HEAVY: i_stall <= ($urandom_range(0, 3) != 0);
                        default:     i_stall <= ~i_stall;
                    endcase
                    @(posedge i_clk);
                end
            end
        end
    end

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [KNOT_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
    endtask

    // count, all knots, then two writes to unmapped indexes that must be dropped
    task automatic program_map();
        write_reg(REG_KNOT_COUNT, KNOT_W'(map_count));
        for (int k = 0; k < NUM_KNOT_REGS; k++) write_reg(REG_KNOT_0 + IDX_W'(k), map_knots[k]);
        write_reg(REG_SPARE_FIRST, KNOT_W'({$urandom, $urandom}));
        write_reg(REG_SPARE_LAST, KNOT_W'({$urandom, $urandom}));
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_item(input logic [VAL_W-1:0] v, input logic re);
        int gap;
        i_valid      <= 1'b1;
        i_value_frac <= v;
        i_row_end    <= re;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 40);
            if (gapless) gap = 0;
            else if ($urandom_range(0, 3) == 0) gap = $urandom_range(1, 25);
            else gap = $urandom_range(0, 3);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // n == 0: arbitrary knots and count; otherwise n knots in non-decreasing order
    function automatic void random_map(input int n);
        int               bp;
        int               step;
        logic [BP_W-1:0]  bp_bits;
        logic [RGB_W-1:0] col;
        if (n == 0) begin
            map_count = CNT_W'($urandom_range(0, 7));
            foreach (map_knots[k]) map_knots[k] = KNOT_W'({$urandom, $urandom});
        end else begin
            map_count = CNT_W'(n);
            bp = ($urandom_range(0, 2) == 0) ? int'($urandom_range(1, 8000)) : 0;
            for (int k = 0; k < NUM_KNOT_REGS; k++) begin
                col = RGB_W'($urandom);
                if (k < n) begin
                    bp_bits = BP_W'(bp);
                    map_knots[k] = {bp_bits, col};
                    if ($urandom_range(0, 7) == 0) step = 0;
                    else step = int'($urandom_range(1, 131072 / (n - 1)));
                    bp = bp + step;
                    if (bp > VAL_MAX) bp = VAL_MAX;
                end else begin
                    map_knots[k] = KNOT_W'({$urandom, $urandom});
                end
            end
        end
    endfunction

    function automatic logic [VAL_W-1:0] pick_value();
        int sel;
        int v;
        sel = $urandom_range(0, 9);
        if (sel < 4) begin
            v = int'(map_knots[$urandom_range(0, NUM_KNOT_REGS - 1)][KNOT_W-1:KNOT_BP_LSB])
                + int'($urandom_range(0, 4)) - 2;
            if (v < 0) v = 0;
            if (v > VAL_MAX) v = VAL_MAX;
            return VAL_W'(v);
        end
        if (sel < 8) return VAL_W'($urandom_range(0, 65536));
        if (sel == 8) return VAL_W'($urandom_range(0, VAL_MAX));
        return VAL_W'($urandom_range(65535, 65537));
    endfunction

    initial begin : stimulus
        i_rst_n      <= 1'b0;
        i_valid      <= 1'b0;
        i_value_frac <= '0;
        i_row_end    <= 1'b0;
        i_cfg_valid  <= 1'b0;
        i_cfg_index  <= '0;
        i_cfg_data   <= '0;
        hold_req     <= 1'b0;
        gapless    = 1'b0;
        burst_left = $urandom_range(1, 40);
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset map, black at 0.0 to white at 1.0
        send_item(17'd0, 1'b0);
        send_item(17'd1, 1'b0);
        send_item(17'd32768, 1'b0);
        send_item(17'd65536, 1'b1);
        send_item(17'd65537, 1'b0);
        send_item(17'h1FFFF, 1'b1);
        drain();

        // seven knots: first above zero, a repeated and a falling breakpoint,
        // last one below 1.0
        map_count    = 3'd7;
        map_knots[0] = {17'd4096,  24'hFF0000};
        map_knots[1] = {17'd10000, 24'h00FF00};
        map_knots[2] = {17'd20000, 24'h0000FF};
        map_knots[3] = {17'd20000, 24'hFFFFFF};
        map_knots[4] = {17'd30000, 24'h000000};
        map_knots[5] = {17'd15000, 24'h80FF01};
        map_knots[6] = {17'd60000, 24'h7F00FE};
        program_map();
        send_item(17'd0, 1'b0);
        send_item(17'd4096, 1'b0);
        send_item(17'd10000, 1'b0);
        send_item(17'd10001, 1'b0);
        send_item(17'd20000, 1'b1);
        send_item(17'd25000, 1'b0);
        send_item(17'd30000, 1'b0);
        send_item(17'd45000, 1'b0);
        send_item(17'd60000, 1'b0);
        send_item(17'd65000, 1'b0);
        send_item(17'd65536, 1'b1);
        drain();

        // count below two, lower breakpoint above the upper one
        map_count    = 3'd0;
        map_knots[0] = '1;
        map_knots[1] = '0;
        program_map();
        send_item(17'd0, 1'b0);
        send_item(17'd65536, 1'b1);
        drain();

        map_count    = 3'd1;
        map_knots[0] = {17'd0, 24'h123456};
        map_knots[1] = {17'd65536, 24'hFEDCBA};
        program_map();
        send_item(17'd12345, 1'b0);
        send_item(17'd65535, 1'b0);
        send_item(17'd65536, 1'b1);
        drain();

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            if (p == 0) random_map(2);
            else if (p == 1) random_map(MAX_KNOTS);
            else if ($urandom_range(0, 3) == 0) random_map(0);
            else random_map($urandom_range(2, MAX_KNOTS));
            program_map();
            gapless = (p == HOLD_PHASE) || (p == GAPLESS_PHASE);
            if (p == HOLD_PHASE) hold_req <= 1'b1;
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
                send_item(pick_value(), $urandom_range(0, 7) == 0);
            drain();
        end

        repeat (END_WAIT) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("piecewise_linear_color_map_tb: PASS");
        else
            $display("piecewise_linear_color_map_tb: FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/plcm_pkg.sv
rtl/plcm_front.sv
rtl/plcm_fifo.sv
rtl/plcm_back.sv
rtl/piecewise_linear_color_map.sv
rtl/plcm_checker.sv
test/plcm_colour_checker.sv
test/piecewise_linear_color_map_tb.sv
